### design/tsdx_pkg.sv
// ----------------------------------------------------------------------------
// tsdx_pkg
// Shared types and constants of the delta-of-delta / XOR sample encoder.
// ----------------------------------------------------------------------------
package tsdx_pkg;

  // input operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // configuration register indexes
  localparam logic CFG_WIDTH_MODE = 1'b0;
  localparam logic CFG_CAPACITY   = 1'b1;

  localparam logic [19:0] CAPACITY_RESET = 20'd4096;

  // byte buffer of one item in the back end
  localparam int BUF_DEPTH = 16;
  localparam int BAW       = $clog2(BUF_DEPTH);

  // front-to-back queue, depth a power of two
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]         op;
    logic signed [63:0] timestamp;
    logic [63:0]        value_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic        overflow_flag;
    logic [19:0] length_bytes;
  } out_item_t;

  typedef enum logic [1:0] {
    K_START,
    K_SAMPLE,
    K_FINISH
  } kind_t;

  // coded item: three MSB-first segments, each left-aligned with its length
  typedef struct packed {
    kind_t       kind;
    logic [35:0] tseg;
    logic [5:0]  tlen;
    logic [12:0] hseg;
    logic [3:0]  hlen;
    logic [63:0] bseg;
    logic [6:0]  blen;
  } entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DOD,
    F_BUILD,
    F_PUSH
  } fstate_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD,
    B_SHIFT,
    B_EMIT
  } bstate_t;

endpackage

### design/tsdx_front.sv
// ----------------------------------------------------------------------------
// tsdx_front
// Takes input items, runs the delta-of-delta and XOR window logic and turns
// each item into a coded entry of three bit segments for the back end.
// ----------------------------------------------------------------------------
module tsdx_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tsdx_pkg::in_item_t in_data,
  input  logic               width_mode,
  input  logic               q_full,
  output logic               q_push,
  output tsdx_pkg::entry_t   q_data
);

  localparam logic [1:0] TP_7  = 2'b10;
  localparam logic [2:0] TP_9  = 3'b110;
  localparam logic [3:0] TP_12 = 4'b1110;
  localparam logic [3:0] TP_32 = 4'b1111;
  localparam logic [1:0] VH_REUSE = 2'b10;
  localparam logic [1:0] VH_NEW   = 2'b11;

  function automatic logic [6:0] lead_zeros(input logic [63:0] v);
    logic [63:0] t;
    logic [6:0]  n;
    t = v;
    n = 7'd0;
    if (v == 64'd0) begin
      n = 7'd64;
    end else begin
      if (t[63:32] == 32'd0) begin
        n[5] = 1'b1;
        t = t << 32;
      end
      if (t[63:48] == 16'd0) begin
        n[4] = 1'b1;
        t = t << 16;
      end
      if (t[63:56] == 8'd0) begin
        n[3] = 1'b1;
        t = t << 8;
      end
      if (t[63:60] == 4'd0) begin
        n[2] = 1'b1;
        t = t << 4;
      end
      if (t[63:62] == 2'd0) begin
        n[1] = 1'b1;
        t = t << 2;
      end
      if (!t[63]) begin
        n[0] = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [6:0] trail_zeros(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[i] = v[63 - i];
    end
    return lead_zeros(r);
  endfunction

  tsdx_pkg::fstate_t st_r, st_nxt;

  // payload
  logic [1:0]       op_r;
  logic [63:0]      ts_r;
  logic [63:0]      bits_r;
  logic [63:0]      delta_r;
  logic [63:0]      x_r;
  logic [63:0]      dod_r;
  logic [6:0]       lz64_r;
  logic [6:0]       tz_r;
  tsdx_pkg::entry_t entry_r;
  tsdx_pkg::entry_t entry_nxt;

  // coder state
  logic [63:0] prev_ts_r;
  logic [63:0] prev_delta_r;
  logic [63:0] prev_val_r;
  logic [4:0]  wl_r;
  logic [6:0]  wt_r;
  logic        seen_val_r;
  logic        seen_win_r;

  logic        accept;
  logic        op_ok;
  logic [63:0] mask;
  logic [63:0] in_bits;
  logic [6:0]  wsub;
  logic [6:0]  wlen;
  logic [6:0]  lz_adj;
  logic [4:0]  lz_cap;
  logic        x_zero;
  logic        reuse;
  logic        new_win;
  logic [6:0]  sh_amt;
  logic [63:0] body;
  logic [6:0]  reuse_len;
  logic [6:0]  sig;
  logic [6:0]  sig_m1;
  logic        fits7;
  logic        fits9;
  logic        fits12;

  assign op_ok   = (in_data.op == tsdx_pkg::OP_START) || (in_data.op == tsdx_pkg::OP_SAMPLE) ||
                   (in_data.op == tsdx_pkg::OP_FINISH);
  assign in_stall = (st_r != tsdx_pkg::F_IDLE);
  assign accept   = in_valid && !in_stall;
  assign mask     = width_mode ? 64'h0000_0000_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
  assign in_bits  = in_data.value_bits & mask;

  assign q_push = (st_r == tsdx_pkg::F_PUSH) && !q_full;
  assign q_data = entry_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tsdx_pkg::F_IDLE: begin
        if (accept && op_ok) begin
          st_nxt = tsdx_pkg::F_DOD;
        end
      end
      tsdx_pkg::F_DOD:   st_nxt = tsdx_pkg::F_BUILD;
      tsdx_pkg::F_BUILD: st_nxt = tsdx_pkg::F_PUSH;
      tsdx_pkg::F_PUSH: begin
        if (!q_full) begin
          st_nxt = tsdx_pkg::F_IDLE;
        end
      end
      default: st_nxt = tsdx_pkg::F_IDLE;
    endcase
  end

  // value window decision
  assign wsub    = width_mode ? 7'd32 : 7'd0;
  assign wlen    = width_mode ? 7'd32 : 7'd64;
  assign lz_adj  = lz64_r - wsub;
  assign lz_cap  = (lz_adj > 7'd31) ? 5'd31 : lz_adj[4:0];
  assign x_zero  = (x_r == 64'd0);
  assign reuse   = seen_win_r && (lz_cap >= wl_r) && (tz_r >= wt_r) &&
                   (({2'b00, wl_r} + wt_r) < wlen);
  assign new_win = seen_val_r && !x_zero && !reuse;
  assign sh_amt  = wsub + {2'b00, (reuse ? wl_r : lz_cap)};
  assign body    = x_r << sh_amt[5:0];
  assign reuse_len = wlen - {2'b00, wl_r} - wt_r;
  assign sig       = wlen - {2'b00, lz_cap} - tz_r;
  assign sig_m1    = sig - 7'd1;

  // signed bucket tests on the delta-of-delta
  assign fits7  = (dod_r[63:6] == '0) || (dod_r[63:6] == '1);
  assign fits9  = (dod_r[63:8] == '0) || (dod_r[63:8] == '1);
  assign fits12 = (dod_r[63:11] == '0) || (dod_r[63:11] == '1);

  always_comb begin
    entry_nxt = '0;
    entry_nxt.kind = tsdx_pkg::K_SAMPLE;
    case (op_r)
      tsdx_pkg::OP_START: begin
        entry_nxt.kind = tsdx_pkg::K_START;
        entry_nxt.bseg = ts_r;
        entry_nxt.blen = 7'd64;
      end
      tsdx_pkg::OP_SAMPLE: begin
        if (dod_r == 64'd0) begin
          entry_nxt.tlen = 6'd1;
        end else if (fits7) begin
          entry_nxt.tseg = {TP_7, dod_r[6:0], 27'd0};
          entry_nxt.tlen = 6'd9;
        end else if (fits9) begin
          entry_nxt.tseg = {TP_9, dod_r[8:0], 24'd0};
          entry_nxt.tlen = 6'd12;
        end else if (fits12) begin
          entry_nxt.tseg = {TP_12, dod_r[11:0], 20'd0};
          entry_nxt.tlen = 6'd16;
        end else begin
          entry_nxt.tseg = {TP_32, dod_r[31:0]};
          entry_nxt.tlen = 6'd36;
        end
        if (!seen_val_r) begin
          entry_nxt.bseg = width_mode ? {bits_r[31:0], 32'd0} : bits_r;
          entry_nxt.blen = wlen;
        end else if (x_zero) begin
          entry_nxt.hlen = 4'd1;
        end else if (reuse) begin
          entry_nxt.hseg = {VH_REUSE, 11'd0};
          entry_nxt.hlen = 4'd2;
          entry_nxt.bseg = body;
          entry_nxt.blen = reuse_len;
        end else begin
          entry_nxt.hseg = {VH_NEW, lz_cap, sig_m1[5:0]};
          entry_nxt.hlen = 4'd13;
          entry_nxt.bseg = body;
          entry_nxt.blen = sig;
        end
      end
      tsdx_pkg::OP_FINISH: begin
        entry_nxt.kind = tsdx_pkg::K_FINISH;
      end
      default: begin
        entry_nxt.kind = tsdx_pkg::K_SAMPLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= tsdx_pkg::F_IDLE;
      prev_ts_r    <= 64'd0;
      prev_delta_r <= 64'd0;
      prev_val_r   <= 64'd0;
      wl_r         <= 5'd0;
      wt_r         <= 7'd0;
      seen_val_r   <= 1'b0;
      seen_win_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == tsdx_pkg::F_BUILD) begin
        if (op_r == tsdx_pkg::OP_START) begin
          prev_ts_r    <= ts_r;
          prev_delta_r <= 64'd0;
          prev_val_r   <= 64'd0;
          wl_r         <= 5'd0;
          wt_r         <= 7'd0;
          seen_val_r   <= 1'b0;
          seen_win_r   <= 1'b0;
        end else if (op_r == tsdx_pkg::OP_SAMPLE) begin
          prev_ts_r    <= ts_r;
          prev_delta_r <= delta_r;
          prev_val_r   <= bits_r;
          seen_val_r   <= 1'b1;
          if (new_win) begin
            wl_r       <= lz_cap;
            wt_r       <= tz_r;
            seen_win_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_data.op;
      ts_r    <= in_data.timestamp;
      bits_r  <= in_bits;
      delta_r <= in_data.timestamp - prev_ts_r;
      x_r     <= (in_bits ^ prev_val_r) & mask;
    end
    if (st_r == tsdx_pkg::F_DOD) begin
      dod_r  <= delta_r - prev_delta_r;
      lz64_r <= lead_zeros(x_r);
      tz_r   <= trail_zeros(x_r);
    end
    if (st_r == tsdx_pkg::F_BUILD) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

### design/tsdx_queue.sv
// ----------------------------------------------------------------------------
// tsdx_queue
// Short FIFO of coded entries between the front and the back end.
// ----------------------------------------------------------------------------
module tsdx_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tsdx_pkg::entry_t push_data,
  input  logic             pop,
  output tsdx_pkg::entry_t head,
  output logic             full,
  output logic             empty
);

  tsdx_pkg::entry_t              mem_r [tsdx_pkg::QDEPTH];
  logic [tsdx_pkg::QAW-1:0]      wp_r;
  logic [tsdx_pkg::QAW-1:0]      rp_r;
  logic [tsdx_pkg::QAW:0]        cnt_r;

  assign full  = (cnt_r == (tsdx_pkg::QAW + 1)'(tsdx_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

### design/tsdx_back.sv
// ----------------------------------------------------------------------------
// tsdx_back
// Packs coded segments into bytes under the capacity limit, collects the
// bytes of one item and hands them out with the item's final status.
// ----------------------------------------------------------------------------
module tsdx_back #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [19:0]         capacity,
  input  logic                q_empty,
  input  tsdx_pkg::entry_t    q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tsdx_pkg::out_item_t out_data
);

  localparam int LW = (COUNT_WIDTH > 20) ? COUNT_WIDTH : 20;
  localparam int BAW = tsdx_pkg::BAW;

  tsdx_pkg::bstate_t   st_r, st_nxt;
  tsdx_pkg::entry_t    ent_r, ent_nxt;
  logic [1:0]          seg_r, seg_nxt;
  logic [63:0]         sh_r, sh_nxt;
  logic [6:0]          rem_r, rem_nxt;
  logic [7:0]          partial_r, partial_nxt;
  logic [2:0]          pc_r, pc_nxt;
  logic [COUNT_WIDTH-1:0] bw_r, bw_nxt;
  logic                ovf_r, ovf_nxt;
  logic [BAW:0]        cnt_r, cnt_nxt;
  logic [BAW:0]        rd_r, rd_nxt;
  logic                out_valid_r, out_valid_nxt;
  tsdx_pkg::out_item_t out_data_r, out_data_nxt;
  logic [7:0]          buf_r [tsdx_pkg::BUF_DEPTH];

  logic                wr_en;
  logic [BAW-1:0]      wr_idx;
  logic [7:0]          wr_byte;

  logic [LW-1:0]       cmax;
  logic [LW-1:0]       cap_ext;
  logic [LW-1:0]       limit;
  logic                at_limit;
  logic [LW:0]         len_full;
  logic [63:0]         seg_data;
  logic [6:0]          seg_len;
  logic [3:0]          room;
  logic [3:0]          k;
  logic [15:0]         cat_sh;
  logic [7:0]          p_new;
  logic [3:0]          sum;
  logic [15:0]         flush_cat;
  logic                fin;
  logic                load_ok;

  always_comb begin
    for (int i = 0; i < LW; i++) begin
      cmax[i] = (i < COUNT_WIDTH);
    end
  end

  assign cap_ext  = LW'(capacity);
  assign limit    = (cap_ext < cmax) ? cap_ext : cmax;
  assign at_limit = (LW'(bw_r) >= limit);
  assign len_full = (LW + 1)'(bw_r) + (LW + 1)'(pc_r != 3'd0);

  always_comb begin
    case (seg_r)
      2'd0: begin
        seg_data = {ent_r.tseg, 28'd0};
        seg_len  = {1'b0, ent_r.tlen};
      end
      2'd1: begin
        seg_data = {ent_r.hseg, 51'd0};
        seg_len  = {3'd0, ent_r.hlen};
      end
      default: begin
        seg_data = ent_r.bseg;
        seg_len  = ent_r.blen;
      end
    endcase
  end

  // take bits up to the next byte boundary or the end of the segment
  assign room      = 4'd8 - {1'b0, pc_r};
  assign k         = (rem_r < {3'd0, room}) ? rem_r[3:0] : room;
  assign cat_sh    = {partial_r, sh_r[63:56]} << k;
  assign p_new     = cat_sh[15:8];
  assign sum       = {1'b0, pc_r} + k;
  assign flush_cat = {partial_r, 8'd0} >> pc_r;
  assign fin       = (ent_r.kind == tsdx_pkg::K_FINISH);
  assign load_ok   = !out_valid_r || !out_stall;

  always_comb begin
    st_nxt        = st_r;
    ent_nxt       = ent_r;
    seg_nxt       = seg_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    partial_nxt   = partial_r;
    pc_nxt        = pc_r;
    bw_nxt        = bw_r;
    ovf_nxt       = ovf_r;
    cnt_nxt       = cnt_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_idx        = cnt_r[BAW-1:0];
    wr_byte       = p_new;
    q_pop         = 1'b0;
    case (st_r)
      tsdx_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_head;
          seg_nxt = 2'd0;
          rem_nxt = 7'd0;
          cnt_nxt = '0;
          rd_nxt  = '0;
          st_nxt  = tsdx_pkg::B_LOAD;
          if (q_head.kind == tsdx_pkg::K_START) begin
            partial_nxt = 8'd0;
            pc_nxt      = 3'd0;
            bw_nxt      = '0;
            ovf_nxt     = 1'b0;
          end else if (q_head.kind == tsdx_pkg::K_FINISH) begin
            st_nxt = tsdx_pkg::B_EMIT;
            // flush the partial byte, zero-padded; capacity is not checked here
            if (pc_r != 3'd0) begin
              wr_en       = 1'b1;
              wr_idx      = '0;
              wr_byte     = flush_cat[7:0];
              cnt_nxt     = (BAW + 1)'(1);
              bw_nxt      = bw_r + COUNT_WIDTH'(1);
              partial_nxt = 8'd0;
              pc_nxt      = 3'd0;
            end
          end
        end
      end
      tsdx_pkg::B_LOAD: begin
        if (seg_r == 2'd3) begin
          st_nxt = tsdx_pkg::B_EMIT;
        end else begin
          sh_nxt  = seg_data;
          rem_nxt = seg_len;
          seg_nxt = seg_r + 2'd1;
          st_nxt  = tsdx_pkg::B_SHIFT;
        end
      end
      tsdx_pkg::B_SHIFT: begin
        if (rem_r == 7'd0) begin
          st_nxt = tsdx_pkg::B_LOAD;
        end else if (at_limit) begin
          // drop the rest of the segment
          ovf_nxt = 1'b1;
          rem_nxt = 7'd0;
        end else begin
          sh_nxt  = sh_r << k;
          rem_nxt = rem_r - {3'd0, k};
          if (sum == 4'd8) begin
            wr_en       = 1'b1;
            cnt_nxt     = cnt_r + (BAW + 1)'(1);
            bw_nxt      = bw_r + COUNT_WIDTH'(1);
            partial_nxt = 8'd0;
            pc_nxt      = 3'd0;
          end else begin
            partial_nxt = p_new;
            pc_nxt      = sum[2:0];
          end
        end
      end
      tsdx_pkg::B_EMIT: begin
        if (rd_r < cnt_r) begin
          if (load_ok) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.out_byte      = buf_r[rd_r[BAW-1:0]];
            out_data_nxt.byte_valid    = 1'b1;
            out_data_nxt.last_of_run   = !fin && (rd_r == cnt_r - (BAW + 1)'(1));
            out_data_nxt.overflow_flag = ovf_r;
            out_data_nxt.length_bytes  = len_full[19:0];
            rd_nxt                     = rd_r + (BAW + 1)'(1);
            if (!fin && (rd_r == cnt_r - (BAW + 1)'(1))) begin
              st_nxt = tsdx_pkg::B_IDLE;
            end
          end
        end else if (fin) begin
          if (load_ok) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.out_byte      = 8'd0;
            out_data_nxt.byte_valid    = 1'b0;
            out_data_nxt.last_of_run   = 1'b1;
            out_data_nxt.overflow_flag = ovf_r;
            out_data_nxt.length_bytes  = len_full[19:0];
            st_nxt                     = tsdx_pkg::B_IDLE;
          end
        end else begin
          // quiet item
          st_nxt = tsdx_pkg::B_IDLE;
        end
      end
      default: st_nxt = tsdx_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= tsdx_pkg::B_IDLE;
      seg_r       <= 2'd0;
      rem_r       <= 7'd0;
      partial_r   <= 8'd0;
      pc_r        <= 3'd0;
      bw_r        <= '0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      seg_r       <= seg_nxt;
      rem_r       <= rem_nxt;
      partial_r   <= partial_nxt;
      pc_r        <= pc_nxt;
      bw_r        <= bw_nxt;
      ovf_r       <= ovf_nxt;
      cnt_r       <= cnt_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    sh_r       <= sh_nxt;
    out_data_r <= out_data_nxt;
    if (wr_en) begin
      buf_r[wr_idx] <= wr_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (BAW + 1)'(tsdx_pkg::BUF_DEPTH))
    else $error("item byte buffer overrun");

  a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (partial_r >> pc_r) == 8'd0)
    else $error("partial byte holds bits above its fill count");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == tsdx_pkg::B_EMIT) |-> (rd_r <= cnt_r))
    else $error("read index past collected bytes");

endmodule

### design/timeseries_dod_xor_encoder_top.sv
// Flow: a sample passes the front end's DOD, BUILD and PUSH states after its transfer; the back
// end pops it, loads its three segments in turn, packs each in chunks (a byte or a segment
// tail) and then moves each collected byte into the output register. The front end takes a
// new item only after the last one has left PUSH and runs ahead through a 2-entry queue; the
// back end hands out all bytes of one item before it pops the next.
// Reset (rst_n low, synchronous) clears the coder state, 64-bit mode, capacity 4096 bytes.
// ----------------------------------------------------------------------------
// timeseries_dod_xor_encoder_top
// Delta-of-delta timestamp and XOR value encoder with byte output stream.
// ----------------------------------------------------------------------------
module timeseries_dod_xor_encoder_top #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsdx_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tsdx_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [19:0]         cfg_wdata
);

  logic             mode_r;
  logic [19:0]      cap_r;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  tsdx_pkg::entry_t q_wdata;
  tsdx_pkg::entry_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cap_r  <= tsdx_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tsdx_pkg::CFG_WIDTH_MODE: mode_r <= cfg_wdata[0];
        tsdx_pkg::CFG_CAPACITY:   cap_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tsdx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .width_mode (mode_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  tsdx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tsdx_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (cap_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
